// ===== rtl/rbf_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants of the gaussian rbf evaluator
// no dependencies

package rbf_pkg;

    localparam int CFG_DW      = 6;
    localparam int ACT_ENTRIES = 1025;
    localparam int ACT_IW      = 11;

    typedef enum logic [1:0] {
        ACT_LOC    = 2'd0,
        ACT_SHAPE  = 2'd1,
        ACT_WEIGHT = 2'd2,
        ACT_ELEM   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        REG_INPUTS  = 2'd0,
        REG_CENTERS = 2'd1,
        REG_OUTPUTS = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic [4:0] ai;
        logic [6:0] ac;
        logic [3:0] ao;
    } cfg_t;

    typedef struct packed {
        action_t            act;
        logic               eval;
        logic [7:0]         idx;
        logic signed [15:0] val;
    } cmd_t;

    typedef logic [15:0] act_rom_t [ACT_ENTRIES];

    // exp(-i/64) in q0.16 by repeated multiplication in q0.32
    function automatic act_rom_t act_rom_build();
        act_rom_t     rom;
        logic [127:0] a;
        logic [127:0] e;
        a = 128'd1 << 32;
        for (int i = 0; i < ACT_ENTRIES; i++)
        begin
            e = (a + 128'd32768) >> 16;
            rom[i] = (e > 128'd65535) ? 16'hffff : e[15:0];
            a = (a * 128'd4228380000 + (128'd1 << 31)) >> 32;
        end
        return rom;
    endfunction

endpackage

// ===== rtl/rbf_front.sv =====
`timescale 1ns / 1ps
// front end: accepts input transactions, drops out-of-range ones, tags evaluations
// depends on rbf_pkg

module rbf_front #(
    parameter int MAX_IN_DIMS  = 8,
    parameter int MAX_CENTERS  = 32,
    parameter int MAX_OUT_DIMS = 4
) (
    input  rbf_pkg::cfg_t       cfg,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          action,
    input  logic [7:0]          index,
    input  logic signed [15:0]  value,
    input  logic                q_full,
    output logic                push,
    output rbf_pkg::cmd_t       cmd
);

    localparam int PAIR_DEPTH   = MAX_CENTERS * MAX_IN_DIMS;
    localparam int WEIGHT_DEPTH = MAX_OUT_DIMS * MAX_CENTERS;

    logic keep;

    always_comb
    begin
        cmd.act  = rbf_pkg::action_t'(action);
        cmd.idx  = index;
        cmd.val  = value;
        cmd.eval = ({1'b0, index} + 9'd1) == {4'd0, cfg.ai};
        unique case (cmd.act)
            rbf_pkg::ACT_LOC,
            rbf_pkg::ACT_SHAPE:  keep = 32'(index) < PAIR_DEPTH;
            rbf_pkg::ACT_WEIGHT: keep = 32'(index) < WEIGHT_DEPTH;
            rbf_pkg::ACT_ELEM:   keep = 32'(index) < MAX_IN_DIMS;
            default:             keep = 1'b0;
        endcase
    end

    assign in_stall = q_full;
    assign push     = in_valid && !q_full && keep;

endmodule

// ===== rtl/rbf_queue.sv =====
`timescale 1ns / 1ps
// two-entry command queue between front and back
// depends on rbf_pkg

module rbf_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  rbf_pkg::cmd_t push_cmd,
    input  logic          pop,
    output rbf_pkg::cmd_t pop_cmd,
    output logic          full,
    output logic          empty
);

    rbf_pkg::cmd_t entry_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;

    assign full    = count_reg == 2'd2;
    assign empty   = count_reg == 2'd0;
    assign pop_cmd = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

// ===== rtl/rbf_back.sv =====
`timescale 1ns / 1ps
// back end: parameter stores, distance pipeline, activation rom, weighted sums
// depends on rbf_pkg

module rbf_back #(
    parameter int MAX_IN_DIMS  = 8,
    parameter int MAX_CENTERS  = 32,
    parameter int MAX_OUT_DIMS = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  rbf_pkg::cfg_t       cfg,
    input  logic                q_empty,
    input  rbf_pkg::cmd_t       cmd,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          out_index,
    output logic signed [31:0]  out_value,
    output logic                last
);

    localparam int PD  = MAX_CENTERS * MAX_IN_DIMS;
    localparam int WD  = MAX_OUT_DIMS * MAX_CENTERS;
    localparam int PAW = (PD > 1) ? $clog2(PD) : 1;
    localparam int WAW = (WD > 1) ? $clog2(WD) : 1;
    localparam int DW  = (MAX_IN_DIMS > 1) ? $clog2(MAX_IN_DIMS) : 1;
    localparam int CW  = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
    localparam int OW  = (MAX_OUT_DIMS > 1) ? $clog2(MAX_OUT_DIMS) : 1;
    localparam int RW  = 56;
    localparam int SW  = 40;
    localparam rbf_pkg::act_rom_t ACT_ROM = rbf_pkg::act_rom_build();

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_DIST   = 6'b000010,
        ST_ADRAIN = 6'b000100,
        ST_WSUM   = 6'b001000,
        ST_WDRAIN = 6'b010000,
        ST_EMIT   = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic signed [15:0] loc_mem [PD];
    logic signed [15:0] shp_mem [PD];
    logic signed [15:0] w_mem   [WD];
    logic signed [15:0] in_vec  [MAX_IN_DIMS];
    logic [15:0]        act_mem [MAX_CENTERS];

    logic [DW-1:0]  d_reg;
    logic [CW-1:0]  c_reg;
    logic [PAW-1:0] base_reg;
    logic [CW-1:0]  cb_reg;
    logic [OW-1:0]  o_reg;
    logic [WAW-1:0] wbase_reg;
    logic [CW-1:0]  act_wr_reg;

    logic va1_reg, la1_reg, fa1_reg;
    logic va2_reg, la2_reg, fa2_reg;
    logic va3_reg, la3_reg, fa3_reg;
    logic va4_reg, la4_reg, fa4_reg;
    logic va5_reg, fa5_reg;
    logic va6_reg, fa6_reg;
    logic vb1_reg, lb1_reg;
    logic vb2_reg, lb2_reg;

    logic signed [15:0]  loc_q_reg, shp_q_reg, x_q_reg;
    logic signed [16:0]  diff2_reg;
    logic signed [15:0]  shp2_reg, shp3_reg;
    logic signed [33:0]  sq3_reg;
    logic signed [49:0]  term4_reg;
    logic signed [RW-1:0] racc_reg;
    logic [rbf_pkg::ACT_IW-1:0] ridx5_reg;
    logic [15:0]         act_q_reg;
    logic [15:0]         aq_reg;
    logic signed [15:0]  wq_reg;
    logic signed [32:0]  prod2_reg;
    logic signed [SW-1:0] sacc_reg;
    logic signed [31:0]  res_reg;

    logic                 out_valid_reg;
    logic [1:0]           out_index_reg;
    logic signed [31:0]   out_value_reg;
    logic                 last_reg;

    logic                 a_issue, a_dl, a_cl;
    logic                 b_issue, b_cl, o_last, emit_go, start;
    logic [PAW-1:0]       pa;
    logic [WAW-1:0]       wa;
    logic signed [RW-1:0] rsum;
    logic signed [SW-1:0] ssum;
    logic signed [SW-1:0] sround;
    logic [rbf_pkg::ACT_IW-1:0] ridx;

    assign a_issue = state_reg == ST_DIST;
    assign a_dl    = 5'(d_reg) == cfg.ai - 5'd1;
    assign a_cl    = 7'(c_reg) == cfg.ac - 7'd1;
    assign b_issue = state_reg == ST_WSUM;
    assign b_cl    = 7'(cb_reg) == cfg.ac - 7'd1;
    assign o_last  = 4'(o_reg) == cfg.ao - 4'd1;
    assign emit_go = (state_reg == ST_EMIT) && (!out_valid_reg || !out_stall);
    assign pop     = (state_reg == ST_IDLE) && !q_empty;
    assign start   = pop && (cmd.act == rbf_pkg::ACT_ELEM) && cmd.eval;
    assign pa      = base_reg + PAW'(d_reg);
    assign wa      = wbase_reg + WAW'(cb_reg);
    assign rsum    = racc_reg + term4_reg;
    assign ssum    = sacc_reg + prod2_reg;
    assign sround  = (ssum + 40'sd2048) >>> 12;

    always_comb
    begin
        if (rsum < 0)
        begin
            ridx = '0;
        end
        else if (rsum[RW-1:30] > 26'd1024)
        begin
            ridx = 11'd1024;
        end
        else
        begin
            ridx = rsum[40:30];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (start) state_next = ST_DIST;
            ST_DIST:   if (a_dl && a_cl) state_next = ST_ADRAIN;
            ST_ADRAIN: if (va6_reg && fa6_reg) state_next = ST_WSUM;
            ST_WSUM:   if (b_cl) state_next = ST_WDRAIN;
            ST_WDRAIN: if (vb2_reg && lb2_reg) state_next = ST_EMIT;
            ST_EMIT:   if (emit_go) state_next = o_last ? ST_IDLE : ST_WSUM;
            default:   state_next = ST_IDLE;
        endcase
    end

    // stores
    always_ff @(posedge clk)
    begin
        if (pop && cmd.act == rbf_pkg::ACT_LOC)
        begin
            loc_mem[PAW'(cmd.idx)] <= cmd.val;
        end
        if (pop && cmd.act == rbf_pkg::ACT_SHAPE)
        begin
            shp_mem[PAW'(cmd.idx)] <= cmd.val;
        end
        if (pop && cmd.act == rbf_pkg::ACT_WEIGHT)
        begin
            w_mem[WAW'(cmd.idx)] <= cmd.val;
        end
        if (pop && cmd.act == rbf_pkg::ACT_ELEM)
        begin
            in_vec[DW'(cmd.idx)] <= cmd.val;
        end
        if (va6_reg)
        begin
            act_mem[act_wr_reg] <= act_q_reg;
        end
        if (a_issue)
        begin
            loc_q_reg <= loc_mem[pa];
            shp_q_reg <= shp_mem[pa];
            x_q_reg   <= in_vec[d_reg];
        end
        if (b_issue)
        begin
            aq_reg <= act_mem[cb_reg];
            wq_reg <= w_mem[wa];
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        diff2_reg <= {loc_q_reg[15], loc_q_reg} - {x_q_reg[15], x_q_reg};
        shp2_reg  <= shp_q_reg;
        sq3_reg   <= diff2_reg * diff2_reg;
        shp3_reg  <= shp2_reg;
        term4_reg <= sq3_reg * shp3_reg;
        if (va4_reg && la4_reg)
        begin
            ridx5_reg <= ridx;
        end
        act_q_reg <= ACT_ROM[ridx5_reg];
        prod2_reg <= $signed({1'b0, aq_reg}) * wq_reg;
        if (vb2_reg && lb2_reg)
        begin
            res_reg <= sround[31:0];
        end
        if (emit_go)
        begin
            out_index_reg <= 2'(o_reg);
            out_value_reg <= res_reg;
            last_reg      <= o_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            d_reg         <= '0;
            c_reg         <= '0;
            base_reg      <= '0;
            cb_reg        <= '0;
            o_reg         <= '0;
            wbase_reg     <= '0;
            act_wr_reg    <= '0;
            va1_reg <= 1'b0; la1_reg <= 1'b0; fa1_reg <= 1'b0;
            va2_reg <= 1'b0; la2_reg <= 1'b0; fa2_reg <= 1'b0;
            va3_reg <= 1'b0; la3_reg <= 1'b0; fa3_reg <= 1'b0;
            va4_reg <= 1'b0; la4_reg <= 1'b0; fa4_reg <= 1'b0;
            va5_reg <= 1'b0; fa5_reg <= 1'b0;
            va6_reg <= 1'b0; fa6_reg <= 1'b0;
            vb1_reg <= 1'b0; lb1_reg <= 1'b0;
            vb2_reg <= 1'b0; lb2_reg <= 1'b0;
            racc_reg      <= '0;
            sacc_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (start)
            begin
                d_reg      <= '0;
                c_reg      <= '0;
                base_reg   <= '0;
                cb_reg     <= '0;
                o_reg      <= '0;
                wbase_reg  <= '0;
                act_wr_reg <= '0;
            end
            else if (a_issue)
            begin
                if (a_dl)
                begin
                    d_reg    <= '0;
                    c_reg    <= c_reg + CW'(1);
                    base_reg <= base_reg + PAW'(MAX_IN_DIMS);
                end
                else
                begin
                    d_reg <= d_reg + DW'(1);
                end
            end

            va1_reg <= a_issue;
            la1_reg <= a_issue && a_dl;
            fa1_reg <= a_issue && a_dl && a_cl;
            va2_reg <= va1_reg; la2_reg <= la1_reg; fa2_reg <= fa1_reg;
            va3_reg <= va2_reg; la3_reg <= la2_reg; fa3_reg <= fa2_reg;
            va4_reg <= va3_reg; la4_reg <= la3_reg; fa4_reg <= fa3_reg;
            va5_reg <= va4_reg && la4_reg;
            fa5_reg <= fa4_reg;
            va6_reg <= va5_reg;
            fa6_reg <= fa5_reg;

            if (va4_reg)
            begin
                racc_reg <= la4_reg ? '0 : rsum;
            end
            if (va6_reg && !start)
            begin
                act_wr_reg <= act_wr_reg + CW'(1);
            end

            if (b_issue && !b_cl)
            begin
                cb_reg <= cb_reg + CW'(1);
            end
            vb1_reg <= b_issue;
            lb1_reg <= b_issue && b_cl;
            vb2_reg <= vb1_reg;
            lb2_reg <= lb1_reg;
            if (vb2_reg)
            begin
                sacc_reg <= lb2_reg ? '0 : ssum;
            end

            if (emit_go)
            begin
                out_valid_reg <= 1'b1;
                cb_reg        <= '0;
                o_reg         <= o_reg + OW'(1);
                wbase_reg     <= wbase_reg + WAW'(MAX_CENTERS);
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_index = out_index_reg;
    assign out_value = out_value_reg;
    assign last      = last_reg;

endmodule

// ===== rtl/gaussian_rbf_network_eval.sv =====
`timescale 1ns / 1ps
// top level of the gaussian rbf evaluator: config registers, front, queue, back
// depends on rbf_pkg, rbf_front, rbf_queue, rbf_back

// Load and element transactions pass through a two-entry queue to the back end,
// which takes them only while idle. The element of the last active dimension starts
// an evaluation: the distance pipeline reads one center-dimension term per cycle
// from the location and shape stores, then the weight pass reads one weight per
// cycle for each output in turn, and each result is handed out on the result
// channel. The single read port of each store sets the pace of both passes.
// No new transaction is taken by the back end during an evaluation.

module gaussian_rbf_network_eval #(
    parameter int MAX_IN_DIMS  = 8,
    parameter int MAX_CENTERS  = 32,
    parameter int MAX_OUT_DIMS = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [1:0]                        cfg_index,
    input  logic [rbf_pkg::CFG_DW-1:0]        cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        action,
    input  logic [7:0]                        index,
    input  logic signed [15:0]                value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [1:0]                        out_index,
    output logic signed [31:0]                out_value,
    output logic                              last
);

    rbf_pkg::cfg_t cfg_reg;
    rbf_pkg::cmd_t push_cmd;
    rbf_pkg::cmd_t pop_cmd;
    logic          push, pop, q_full, q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ai <= 5'd1;
            cfg_reg.ac <= 7'd1;
            cfg_reg.ao <= 4'd1;
        end
        else if (cfg_we)
        begin
            unique case (rbf_pkg::reg_index_t'(cfg_index))
                rbf_pkg::REG_INPUTS:
                begin
                    if (cfg_data[3:0] == 4'd0)
                        cfg_reg.ai <= 5'd1;
                    else if (32'(cfg_data[3:0]) > MAX_IN_DIMS)
                        cfg_reg.ai <= 5'(MAX_IN_DIMS);
                    else
                        cfg_reg.ai <= {1'b0, cfg_data[3:0]};
                end
                rbf_pkg::REG_CENTERS:
                begin
                    if (cfg_data[5:0] == 6'd0)
                        cfg_reg.ac <= 7'd1;
                    else if (32'(cfg_data[5:0]) > MAX_CENTERS)
                        cfg_reg.ac <= 7'(MAX_CENTERS);
                    else
                        cfg_reg.ac <= {1'b0, cfg_data[5:0]};
                end
                rbf_pkg::REG_OUTPUTS:
                begin
                    if (cfg_data[2:0] == 3'd0)
                        cfg_reg.ao <= 4'd1;
                    else if (32'(cfg_data[2:0]) > MAX_OUT_DIMS)
                        cfg_reg.ao <= 4'(MAX_OUT_DIMS);
                    else
                        cfg_reg.ao <= {1'b0, cfg_data[2:0]};
                end
                default:
                begin
                end
            endcase
        end
    end

    rbf_front #(
        .MAX_IN_DIMS  (MAX_IN_DIMS),
        .MAX_CENTERS  (MAX_CENTERS),
        .MAX_OUT_DIMS (MAX_OUT_DIMS)
    ) u_front (
        .cfg      (cfg_reg),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .action   (action),
        .index    (index),
        .value    (value),
        .q_full   (q_full),
        .push     (push),
        .cmd      (push_cmd)
    );

    rbf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .full     (q_full),
        .empty    (q_empty)
    );

    rbf_back #(
        .MAX_IN_DIMS  (MAX_IN_DIMS),
        .MAX_CENTERS  (MAX_CENTERS),
        .MAX_OUT_DIMS (MAX_OUT_DIMS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .cmd       (pop_cmd),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_index (out_index),
        .out_value (out_value),
        .last      (last)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && q_full))
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && q_empty))
        else $error("queue underflow");

    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last) |-> (out_index == 2'(cfg_reg.ao - 4'd1)))
        else $error("last transaction on wrong output");

endmodule

// ===== test/rbf_checker.sv =====
`timescale 1ns / 1ps
// scoreboard for the gaussian rbf evaluator: watches config writes and both channels
// predicts every result from its own copy of the stores and compares; depends on rbf_pkg

module rbf_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [1:0]                 cfg_index,
    input  logic [rbf_pkg::CFG_DW-1:0] cfg_data,
    input  logic                       in_valid,
    input  logic                       in_stall,
    input  logic [1:0]                 action,
    input  logic [7:0]                 index,
    input  logic signed [15:0]         value,
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  logic [1:0]                 out_index,
    input  logic signed [31:0]         out_value,
    input  logic                       last,
    output int                         fail_count,
    output int                         pending
);

    localparam int IN_DIMS  = 8;
    localparam int CENTERS  = 32;
    localparam int OUT_DIMS = 4;

    typedef struct {
        logic [1:0]         oidx;
        logic signed [31:0] oval;
        logic               olast;
    } net_result_t;

    net_result_t        result_q[$];
    logic [15:0]        exp_rom[1025];
    logic signed [15:0] loc_mem[IN_DIMS*CENTERS];
    logic signed [15:0] shape_mem[IN_DIMS*CENTERS];
    logic signed [15:0] weight_mem[OUT_DIMS*CENTERS];
    logic signed [15:0] x_vec[IN_DIMS];
    int                 n_in;
    int                 n_ctr;
    int                 n_out;
    int                 shown;

    assign pending = result_q.size();

    initial
    begin
        longint unsigned acc;
        longint unsigned rnd;
        acc = 64'd1 << 32;
        for (int i = 0; i < 1025; i++)
        begin
            rnd = (acc + 64'd32768) >> 16;
            exp_rom[i] = (rnd > 64'd65535) ? 16'hffff : rnd[15:0];
            acc = (acc * 64'd4228380000 + (64'd1 << 31)) >> 32;
        end
        fail_count = 0;
        shown = 0;
        n_in = 1;
        n_ctr = 1;
        n_out = 1;
    end

    function automatic int clamp_count(int raw, int maxv);
        if (raw < 1)
            return 1;
        if (raw > maxv)
            return maxv;
        return raw;
    endfunction

    function automatic logic [15:0] center_activation(int c);
        longint r_sum;
        longint diff;
        longint pos;
        int     a;
        r_sum = 0;
        for (int d = 0; d < n_in; d++)
        begin
            a = c * IN_DIMS + d;
            diff = longint'(loc_mem[a]) - longint'(x_vec[d]);
            r_sum += diff * diff * longint'(shape_mem[a]);
        end
        if (r_sum < 0)
            r_sum = 0;
        pos = r_sum >>> 30;
        if (pos > 1024)
            pos = 1024;
        return exp_rom[pos];
    endfunction

    function automatic void predict_outputs();
        logic [15:0]   acts[CENTERS];
        longint        sum;
        longint        q;
        net_result_t   r;
        for (int c = 0; c < n_ctr; c++)
            acts[c] = center_activation(c);
        for (int o = 0; o < n_out; o++)
        begin
            sum = 0;
            for (int c = 0; c < n_ctr; c++)
                sum += longint'(acts[c]) * longint'(weight_mem[o * CENTERS + c]);
            q = (sum + 2048) >>> 12;
            if (q > 64'sd2147483647)
                q = 64'sd2147483647;
            if (q < -64'sd2147483648)
                q = -64'sd2147483648;
            r.oidx = o[1:0];
            r.oval = q[31:0];
            r.olast = (o + 1 == n_out);
            result_q.push_back(r);
        end
    endfunction

    always @(posedge clk)
    begin
        net_result_t exp_r;
        int          idx;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                case (rbf_pkg::reg_index_t'(cfg_index))
                    rbf_pkg::REG_INPUTS:
                        n_in  = clamp_count(int'(cfg_data & 6'h0f), IN_DIMS);
                    rbf_pkg::REG_CENTERS:
                        n_ctr = clamp_count(int'(cfg_data & 6'h3f), CENTERS);
                    rbf_pkg::REG_OUTPUTS:
                        n_out = clamp_count(int'(cfg_data & 6'h07), OUT_DIMS);
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                idx = int'(index);
                case (rbf_pkg::action_t'(action))
                    rbf_pkg::ACT_LOC:    loc_mem[idx] = value;
                    rbf_pkg::ACT_SHAPE:  shape_mem[idx] = value;
                    rbf_pkg::ACT_WEIGHT:
                    begin
                        if (idx < OUT_DIMS * CENTERS)
                            weight_mem[idx] = value;
                    end
                    rbf_pkg::ACT_ELEM:
                    begin
                        if (idx < IN_DIMS)
                        begin
                            x_vec[idx] = value;
                            if (idx + 1 == n_in)
                                predict_outputs();
                        end
                    end
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (result_q.size() == 0)
                begin
                    fail_count++;
                    if (shown < 10)
                        $display("unexpected result transaction idx=%0d val=%0d last=%0b",
                                 out_index, out_value, last);
                    shown++;
                end
                else
                begin
                    exp_r = result_q.pop_front();
                    if (out_index !== exp_r.oidx || out_value !== exp_r.oval
                        || last !== exp_r.olast)
                    begin
                        fail_count++;
                        if (shown < 10)
                            $display({"mismatch: expected idx=%0d val=%0d last=%0b, ",
                                      "got idx=%0d val=%0d last=%0b"},
                                     exp_r.oidx, exp_r.oval, exp_r.olast,
                                     out_index, out_value, last);
                        shown++;
                    end
                end
            end
        end
    end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// testbench top for gaussian_rbf_network_eval: clock, reset, stimulus and verdict
// depends on rbf_pkg, rbf_checker and the block itself

module tb_top;

    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int         CYCLE_LIMIT = 2000000;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [1:0]                 cfg_index;
    logic [rbf_pkg::CFG_DW-1:0] cfg_data;
    logic                       in_valid;
    logic                       in_stall;
    logic [1:0]                 action;
    logic [7:0]                 index;
    logic signed [15:0]         value;
    logic                       out_valid;
    logic                       out_stall;
    logic [1:0]                 out_index;
    logic signed [31:0]         out_value;
    logic                       last;
    int                         fail_count;
    int                         pending;

    int  hold_id;
    int  hold_seen;
    int  hold_left;
    int  burst_left;
    int  quiet_left;
    int  cycles;
    bit  no_gaps;
    int  n_in;
    int  n_ctr;
    int  n_out;
    int  items;
    bit  loc_set[256];
    bit  shape_set[256];
    bit  weight_set[128];
    bit  x_set[8];

    gaussian_rbf_network_eval u_top (.*);

    rbf_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("gaussian_rbf_network_eval regression: fail");
            $finish;
        end
    end

    // result side back-pressure
    always @(posedge clk)
    begin
        int r;
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else if (hold_id != hold_seen)
        begin
            hold_seen = hold_id;
            hold_left = 400;
            out_stall <= 1'b1;
        end
        else if (quiet_left > 0)
        begin
            out_stall <= 1'b0;
            quiet_left--;
        end
        else if (burst_left > 0)
        begin
            out_stall <= 1'b1;
            burst_left--;
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 2)
                burst_left = $urandom_range(10, 60);
            else if (r < 5)
                quiet_left = $urandom_range(50, 300);
            out_stall <= (r >= 5 && r < 30);
        end
    end

    function automatic logic [15:0] pick_value();
        if ($urandom_range(0, 3) == 0)
            return 16'($urandom());
        return 16'($signed($urandom_range(0, 16384)) - 8192);
    endfunction

    function automatic logic [15:0] pick_shape();
        if ($urandom_range(0, 7) == 0)
            return 16'($urandom());
        return 16'($urandom_range(0, 400));
    endfunction

    task automatic send(rbf_pkg::action_t a, int idx, logic [15:0] v);
        int gap;
        int r;
        r = $urandom_range(0, 99);
        gap = 0;
        if (!no_gaps)
        begin
            if (r < 25)
                gap = $urandom_range(1, 3);
            else if (r < 30)
                gap = $urandom_range(10, 50);
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= a;
        index <= idx[7:0];
        value <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        case (a)
            rbf_pkg::ACT_LOC:    loc_set[idx] = 1'b1;
            rbf_pkg::ACT_SHAPE:  shape_set[idx] = 1'b1;
            rbf_pkg::ACT_WEIGHT: if (idx < 128) weight_set[idx] = 1'b1;
            rbf_pkg::ACT_ELEM:   if (idx < 8) x_set[idx] = 1'b1;
        endcase
        items++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    // leaves cfg_we high, the caller drops it after the last write
    task automatic write_reg(logic [1:0] ri, int data);
        cfg_we <= 1'b1;
        cfg_index <= ri;
        cfg_data <= data[rbf_pkg::CFG_DW-1:0];
        @(posedge clk);
    endtask

    task automatic set_shape(int ni, int nc, int no);
        settle();
        write_reg(rbf_pkg::REG_INPUTS, ni);
        write_reg(rbf_pkg::REG_CENTERS, nc);
        write_reg(rbf_pkg::REG_OUTPUTS, no);
        cfg_we <= 1'b0;
        n_in = ni;
        n_ctr = nc;
        n_out = no;
    endtask

    task automatic fill_stores();
        for (int c = 0; c < n_ctr; c++)
            for (int d = 0; d < n_in; d++)
            begin
                if (!loc_set[c * 8 + d])
                    send(rbf_pkg::ACT_LOC, c * 8 + d, pick_value());
                if (!shape_set[c * 8 + d])
                    send(rbf_pkg::ACT_SHAPE, c * 8 + d, pick_shape());
            end
        for (int o = 0; o < n_out; o++)
            for (int c = 0; c < n_ctr; c++)
                if (!weight_set[o * 32 + c])
                    send(rbf_pkg::ACT_WEIGHT, o * 32 + c, pick_value());
    endtask

    // sends the element that starts an evaluation, earlier dims first if never set
    task automatic evaluate(logic [15:0] v);
        for (int d = 0; d < n_in - 1; d++)
            if (!x_set[d])
                send(rbf_pkg::ACT_ELEM, d, pick_value());
        send(rbf_pkg::ACT_ELEM, n_in - 1, v);
    endtask

    task automatic random_item();
        int r;
        int d;
        r = $urandom_range(0, 99);
        if (r < 40)
        begin
            d = $urandom_range(0, n_in - 1);
            if (d == n_in - 1)
                evaluate(pick_value());
            else
                send(rbf_pkg::ACT_ELEM, d, pick_value());
        end
        else if (r < 60)
            send(rbf_pkg::ACT_LOC, $urandom_range(0, 255), pick_value());
        else if (r < 78)
            send(rbf_pkg::ACT_SHAPE, $urandom_range(0, 255), pick_shape());
        else if (r < 92)
            send(rbf_pkg::ACT_WEIGHT, $urandom_range(0, 127), pick_value());
        else if (r < 96)
            send(rbf_pkg::ACT_ELEM, $urandom_range(8, 255), 16'($urandom()));
        else
            send(rbf_pkg::ACT_WEIGHT, $urandom_range(128, 255), 16'($urandom()));
    endtask

    initial
    begin
        int phase;
        int cnt;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        action = '0;
        index = '0;
        value = '0;
        out_stall = 1'b0;
        hold_id = 0;
        hold_seen = 0;
        no_gaps = 1'b0;
        n_in = 1;
        n_ctr = 1;
        n_out = 1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: default sizes, field extremes
        send(rbf_pkg::ACT_LOC, 0, 16'sh1000);
        send(rbf_pkg::ACT_SHAPE, 0, 16'sh0100);
        send(rbf_pkg::ACT_WEIGHT, 0, 16'sh7fff);
        send(rbf_pkg::ACT_ELEM, 0, 16'sh1000);
        send(rbf_pkg::ACT_LOC, 0, 16'sh7fff);
        send(rbf_pkg::ACT_SHAPE, 0, 16'sh7fff);
        send(rbf_pkg::ACT_WEIGHT, 0, 16'sh8000);
        send(rbf_pkg::ACT_ELEM, 0, 16'sh8000);
        send(rbf_pkg::ACT_SHAPE, 0, 16'sh8000);
        send(rbf_pkg::ACT_ELEM, 0, 16'sh0000);
        send(rbf_pkg::ACT_ELEM, 8, 16'shffff);
        send(rbf_pkg::ACT_ELEM, 255, 16'sh5555);
        send(rbf_pkg::ACT_WEIGHT, 255, 16'shaaaa);
        send(rbf_pkg::ACT_LOC, 255, 16'shffff);
        send(rbf_pkg::ACT_SHAPE, 255, 16'sh0000);
        send(rbf_pkg::ACT_SHAPE, 0, 16'sh0040);
        send(rbf_pkg::ACT_ELEM, 0, 16'sh7fff);

        // out-of-range register values clamp, unused index ignored
        settle();
        write_reg(rbf_pkg::REG_INPUTS, 0);
        write_reg(rbf_pkg::REG_CENTERS, 63);
        write_reg(rbf_pkg::REG_OUTPUTS, 7);
        write_reg(REG_UNUSED, 5);
        cfg_we <= 1'b0;
        n_in = 1;
        n_ctr = 32;
        n_out = 4;
        fill_stores();
        evaluate(16'sh0400);
        settle();
        write_reg(rbf_pkg::REG_INPUTS, 15);
        write_reg(rbf_pkg::REG_CENTERS, 0);
        write_reg(rbf_pkg::REG_OUTPUTS, 0);
        cfg_we <= 1'b0;
        n_in = 8;
        n_ctr = 1;
        n_out = 1;
        fill_stores();
        send(rbf_pkg::ACT_ELEM, 2, 16'sh0100);
        evaluate(16'shf000);

        phase = 0;
        while (items < 400)
        begin
            case (phase % 6)
                0: set_shape(1, 1, 1);
                default: set_shape($urandom_range(1, 8), $urandom_range(1, 12),
                                   $urandom_range(1, 4));
            endcase
            no_gaps = (phase % 4 == 2);
            fill_stores();
            if (phase == 1)
            begin
                hold_id <= hold_id + 1;
                evaluate(pick_value());
            end
            cnt = (n_ctr > 16) ? $urandom_range(8, 15) : $urandom_range(20, 45);
            for (int k = 0; k < cnt; k++)
                random_item();
            phase++;
        end
        no_gaps = 1'b0;

        settle();
        repeat (100) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("gaussian_rbf_network_eval regression: pass");
        else
            $display("gaussian_rbf_network_eval regression: fail");
        $finish;
    end

endmodule
